@@ design/xibe_pkg.sv @@
package xibe_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxBytes = 12;
  localparam int unsigned LenWidth = 4;

  localparam logic [7:0] OpRex     = 8'h40;
  localparam logic [7:0] OpMovImm  = 8'hB8;
  localparam logic [7:0] OpMovStr  = 8'h89;
  localparam logic [7:0] OpMovLd   = 8'h8B;
  localparam logic [7:0] OpSib     = 8'h24;
  localparam logic [7:0] OpEsc     = 8'h0F;
  localparam logic [7:0] OpJmp     = 8'hE9;
  localparam logic [7:0] OpCall    = 8'hE8;
  localparam logic [7:0] OpRet     = 8'hC3;
  localparam logic [7:0] OpCdq     = 8'h99;
  localparam logic [7:0] OpGrp1    = 8'h81;
  localparam logic [7:0] OpGrp2    = 8'hC1;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenWidth-1:0]      len;
  } seq_t;

endpackage

@@ design/x86_64_instruction_byte_encoder.sv @@
// Encodes one instruction request into its x86-64 bytes, one byte per output request.
// The front stage classifies a request and builds the whole byte sequence at once
// into a two-entry queue; the back stage emits one byte per cycle while out_ready_i
// does not stall it. A request has 1 to 10 bytes. Undefined forms produce no output.
// Each byte is flagged stored while the byte count is below the capacity written on
// cfg_data_i and not saturated; writing the capacity clears the count.
module x86_64_instruction_byte_encoder #(
  parameter int unsigned COUNT_WIDTH = xibe_pkg::CountWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic [5:0]         req_type_i,
  input  logic [3:0]         dest_reg_i,
  input  logic [3:0]         source_reg_i,
  input  logic [63:0]        immediate_i,
  input  logic signed [31:0] displacement_i,
  input  logic [3:0]         cond_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_byte_o,
  output logic               stored_o
);
  import xibe_pkg::*;

  seq_t seq;
  logic seq_valid, seq_ready;

  xibe_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_type_i, .dest_reg_i,
    .source_reg_i, .immediate_i, .displacement_i, .cond_code_i,
    .seq_valid_o(seq_valid), .seq_ready_i(seq_ready), .seq_o(seq)
  );

  xibe_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .seq_valid_i(seq_valid), .seq_ready_o(seq_ready), .seq_i(seq),
    .out_valid_o, .out_ready_i, .out_byte_o, .last_byte_o, .stored_o
  );
endmodule

@@ design/xibe_front.sv @@
module xibe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [5:0]           req_type_i,
  input  logic [3:0]           dest_reg_i,
  input  logic [3:0]           source_reg_i,
  input  logic [63:0]          immediate_i,
  input  logic signed [31:0]   displacement_i,
  input  logic [3:0]           cond_code_i,
  output logic                 seq_valid_o,
  input  logic                 seq_ready_i,
  output xibe_pkg::seq_t       seq_o
);
  import xibe_pkg::*;

  seq_t        seq_c;
  logic        known_c;
  logic [7:0]  b [MaxBytes];
  logic [LenWidth-1:0] n;
  logic [31:0] lo, rel, dsp;
  logic [2:0]  d7, s7, ext;
  logic        near_disp, dz;
  logic [1:0]  md;
  logic [7:0]  opc;
  logic [4:0]  i1;

  seq_t                       q_mem_q [QueueDepth];
  logic [$clog2(QueueDepth):0] cnt_q;
  logic [$clog2(QueueDepth)-1:0] wp_q, rp_q;

  always_comb begin
    for (int k = 0; k < MaxBytes; k++) b[k] = 8'h00;
    n = '0;
    known_c = 1'b1;
    lo = immediate_i[31:0];
    dsp = displacement_i;
    rel = dsp - 32'd4;
    d7 = dest_reg_i[2:0];
    s7 = source_reg_i[2:0];
    near_disp = (dsp <= 32'd127) || (dsp >= 32'hFFFFFF80);
    dz = (dsp == 32'd0);
    md = 2'd0;
    opc = 8'h00;
    ext = 3'd0;
    i1 = req_type_i[4:0] - 5'd13;
    if (req_type_i == 6'd0) begin
      b[0] = OpRex | 8'h08 | {7'd0, dest_reg_i[3]};
      b[1] = OpMovImm + {5'd0, d7};
      {b[5], b[4], b[3], b[2]} = lo;
      {b[9], b[8], b[7], b[6]} = immediate_i[63:32];
      n = 4'd10;
    end else if (req_type_i <= 6'd9 && req_type_i != 6'd7) begin
      case (req_type_i[3:0])
        4'd1: opc = OpMovStr;
        4'd2: opc = 8'h01;
        4'd3: opc = 8'h29;
        4'd4: opc = 8'h21;
        4'd5: opc = 8'h09;
        4'd6: opc = 8'h31;
        4'd8: opc = 8'h39;
        default: opc = 8'h85;
      endcase
      b[0] = 8'h48 | {5'd0, source_reg_i[3], 1'b0, dest_reg_i[3]};
      b[1] = opc;
      b[2] = {2'b11, s7, d7};
      n = 4'd3;
    end else if (req_type_i <= 6'd12) begin
      case (req_type_i[3:0])
        4'd7:  opc = 8'hAF;
        4'd10: opc = OpRex | {4'd0, cond_code_i};
        4'd11: opc = 8'hBD;
        default: opc = 8'hBC;
      endcase
      if (req_type_i >= 6'd11) begin
        b[0] = 8'hF3;
        b[1] = 8'h48 | {5'd0, dest_reg_i[3], 1'b0, source_reg_i[3]};
        b[2] = OpEsc; b[3] = opc; b[4] = {2'b11, d7, s7};
        n = 4'd5;
      end else begin
        b[0] = 8'h48 | {5'd0, dest_reg_i[3], 1'b0, source_reg_i[3]};
        b[1] = OpEsc; b[2] = opc; b[3] = {2'b11, d7, s7};
        n = 4'd4;
      end
    end else if (req_type_i <= 6'd23) begin
      b[0] = 8'h48 | {7'd0, dest_reg_i[3]};
      case (i1)
        5'd0: ext = 3'd4; 5'd1: ext = 3'd6; 5'd2: ext = 3'd7;
        5'd3: ext = 3'd4; 5'd4: ext = 3'd5; 5'd5: ext = 3'd7;
        5'd6: ext = 3'd1; 5'd7: ext = 3'd2; 5'd8: ext = 3'd3;
        default: ext = 3'd0;
      endcase
      if (i1 == 5'd10) begin
        b[1] = OpEsc; b[2] = 8'hC8 + {5'd0, d7}; n = 4'd3;
      end else if (i1 >= 5'd3 && i1 <= 5'd6) begin
        b[1] = OpGrp2; b[2] = {2'b11, ext, d7}; b[3] = immediate_i[7:0]; n = 4'd4;
      end else begin
        b[1] = 8'hF7; b[2] = {2'b11, ext, d7};
        if (i1 == 5'd9) begin
          {b[6], b[5], b[4], b[3]} = lo; n = 4'd7;
        end else n = 4'd3;
      end
    end else if (req_type_i <= 6'd29) begin
      case (req_type_i)
        6'd24: ext = 3'd0; 6'd25: ext = 3'd5; 6'd26: ext = 3'd4;
        6'd27: ext = 3'd1; 6'd28: ext = 3'd6; default: ext = 3'd7;
      endcase
      b[0] = 8'h48 | {7'd0, dest_reg_i[3]};
      b[1] = OpGrp1; b[2] = {2'b11, ext, d7};
      {b[6], b[5], b[4], b[3]} = lo;
      n = 4'd7;
    end else if (req_type_i <= 6'd31) begin
      b[0] = 8'h48 | {5'd0, dest_reg_i[3], 1'b0, source_reg_i[3]};
      b[1] = req_type_i[0] ? OpMovStr : OpMovLd;
      if (dz && s7 != 3'd5) md = 2'd0;
      else if (near_disp) md = 2'd1;
      else md = 2'd2;
      b[2] = {md, d7, s7};
      n = 4'd3;
      if (s7 == 3'd4) begin
        b[3] = OpSib; n = 4'd4;
      end
      if (md == 2'd1) begin
        b[n] = dsp[7:0]; n = n + 4'd1;
      end else if (md == 2'd2) begin
        b[n] = dsp[7:0]; b[n+4'd1] = dsp[15:8];
        b[n+4'd2] = dsp[23:16]; b[n+4'd3] = dsp[31:24]; n = n + 4'd4;
      end
    end else if (req_type_i == 6'd32 || req_type_i == 6'd34) begin
      b[0] = req_type_i[1] ? OpCall : OpJmp;
      {b[4], b[3], b[2], b[1]} = rel; n = 4'd5;
    end else if (req_type_i == 6'd33) begin
      b[0] = OpEsc; b[1] = 8'h80 | {4'd0, cond_code_i};
      {b[5], b[4], b[3], b[2]} = rel; n = 4'd6;
    end else if (req_type_i == 6'd35) begin
      b[0] = OpRet; n = 4'd1;
    end else if (req_type_i == 6'd36) begin
      b[0] = OpCdq; n = 4'd1;
    end else if (req_type_i == 6'd37) begin
      b[0] = 8'h48; b[1] = OpCdq; n = 4'd2;
    end else if (req_type_i == 6'd38) begin
      b[0] = 8'h90; n = 4'd1;
    end else if (req_type_i == 6'd39) begin
      b[0] = 8'hCC; n = 4'd1;
    end else known_c = 1'b0;
    for (int k = 0; k < MaxBytes; k++) seq_c.bytes[k] = b[k];
    seq_c.len = n;
  end

  logic push, pop;
  assign req_ready_o = (cnt_q != QueueDepth[$clog2(QueueDepth):0]);
  assign push = req_valid_i && req_ready_o && known_c;
  assign seq_valid_o = (cnt_q != '0);
  assign pop = seq_valid_o && seq_ready_i;
  assign seq_o = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= seq_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= '0; rp_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{$clog2(QueueDepth){1'b0}}, push}
                     - {{$clog2(QueueDepth){1'b0}}, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueDepth[$clog2(QueueDepth):0]) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_valid_o |-> (seq_o.len != '0)) else $error("empty sequence queued");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count slip");
endmodule

@@ design/xibe_back.sv @@
module xibe_back #(
  parameter int unsigned COUNT_WIDTH = xibe_pkg::CountWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 seq_valid_i,
  output logic                 seq_ready_o,
  input  xibe_pkg::seq_t       seq_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_byte_o,
  output logic                 stored_o
);
  import xibe_pkg::*;

  logic [LenWidth-1:0]    idx_q;
  logic [15:0]            cap_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic                   ov_q;
  logic [7:0]             byte_q;
  logic                   last_q, st_q;
  logic                   ok, last_c, load;

  assign ok = (33'(cnt_q) < 33'(cap_q)) && (cnt_q != {COUNT_WIDTH{1'b1}});
  assign last_c = (idx_q + 1'b1 == seq_i.len);
  assign load = seq_valid_i && (!ov_q || out_ready_i);
  assign seq_ready_o = load && last_c;

  assign out_valid_o = ov_q;
  assign out_byte_o = byte_q;
  assign last_byte_o = last_q;
  assign stored_o = st_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= seq_i.bytes[idx_q];
      last_q <= last_c;
      st_q   <= ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; cap_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
        idx_q <= last_c ? '0 : idx_q + 1'b1;
        if (ok) cnt_q <= cnt_q + 1'b1;
      end else if (out_ready_i) ov_q <= 1'b0;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
        cnt_q <= '0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_valid_i |-> (idx_q < seq_i.len)) else $error("index past length");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ok && !cfg_we_i) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !ok && !cfg_we_i) |=> $stable(cnt_q)) else $error("count moved");
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       st;
  } byte_exp_t;

  typedef struct {
    logic [5:0]  t;
    logic [3:0]  d;
    logic [3:0]  s;
    logic [63:0] imm;
    logic [31:0] disp;
    logic [3:0]  cc;
    bit          known;
    int          klen;
    logic [15:0] kb;
  } insn_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        req_valid_i = 1'b0;
  logic        req_ready_o;
  logic [5:0]  req_type_i = '0;
  logic [3:0]  dest_reg_i = '0;
  logic [3:0]  source_reg_i = '0;
  logic [63:0] immediate_i = '0;
  logic signed [31:0] displacement_i = '0;
  logic [3:0]  cond_code_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;
  logic        stored_o;

  logic [15:0] capacity;
  logic [15:0] byte_count;
  logic [7:0]  insn_bytes[$];
  byte_exp_t   pending_bytes[$];
  int          errors = 0;
  bit          no_idle = 1'b0;
  int          out_stall = 0;
  insn_row_t   rows[$];

  x86_64_instruction_byte_encoder u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_type_i(req_type_i),
    .dest_reg_i(dest_reg_i), .source_reg_i(source_reg_i), .immediate_i(immediate_i),
    .displacement_i(displacement_i), .cond_code_i(cond_code_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_byte_o(out_byte_o),
    .last_byte_o(last_byte_o), .stored_o(stored_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rex(input logic r, input logic b);
    return 8'h48 | {5'b0, r, 1'b0, b};
  endfunction

  function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                       input logic [2:0] rm);
    return {md, rg, rm};
  endfunction

  function automatic void put32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) insn_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void encode_mem(input logic [7:0] opc, input logic [3:0] rg,
                                     input logic [3:0] base, input logic [31:0] disp);
    logic       near;
    logic [1:0] md;
    near = (disp <= 32'd127) || (disp >= 32'hFFFFFF80);
    insn_bytes.push_back(rex(rg[3], base[3]));
    insn_bytes.push_back(opc);
    if (disp == 0 && base[2:0] != 3'd5) md = 2'd0;
    else if (near) md = 2'd1;
    else md = 2'd2;
    insn_bytes.push_back(modrm(md, rg[2:0], base[2:0]));
    if (base[2:0] == 3'd4) insn_bytes.push_back(xibe_pkg::OpSib);
    if (md == 2'd1) insn_bytes.push_back(disp[7:0]);
    else if (md == 2'd2) put32(disp);
  endfunction

  function automatic void build_encoding(input insn_row_t q);
    logic [7:0] rr_opc[9];
    logic [2:0] one_ext[11];
    logic [2:0] imm_ext[6];
    int         i;
    rr_opc = '{8'h89, 8'h01, 8'h29, 8'h21, 8'h09, 8'h31, 8'h00, 8'h39, 8'h85};
    one_ext = '{3'd4, 3'd6, 3'd7, 3'd4, 3'd5, 3'd7, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0};
    imm_ext = '{3'd0, 3'd5, 3'd4, 3'd1, 3'd6, 3'd7};
    insn_bytes.delete();
    if (q.t == 0) begin
      insn_bytes.push_back(rex(1'b0, q.d[3]));
      insn_bytes.push_back(xibe_pkg::OpMovImm + q.d[2:0]);
      put32(q.imm[31:0]);
      put32(q.imm[63:32]);
    end else if (q.t <= 9 && q.t != 7) begin
      insn_bytes.push_back(rex(q.s[3], q.d[3]));
      insn_bytes.push_back(rr_opc[q.t - 1]);
      insn_bytes.push_back(modrm(2'd3, q.s[2:0], q.d[2:0]));
    end else if (q.t <= 12) begin
      if (q.t >= 11) insn_bytes.push_back(8'hF3);
      insn_bytes.push_back(rex(q.d[3], q.s[3]));
      insn_bytes.push_back(xibe_pkg::OpEsc);
      if (q.t == 7) insn_bytes.push_back(8'hAF);
      else if (q.t == 10) insn_bytes.push_back(8'h40 | q.cc);
      else if (q.t == 11) insn_bytes.push_back(8'hBD);
      else insn_bytes.push_back(8'hBC);
      insn_bytes.push_back(modrm(2'd3, q.d[2:0], q.s[2:0]));
    end else if (q.t <= 23) begin
      i = q.t - 13;
      insn_bytes.push_back(rex(1'b0, q.d[3]));
      if (i == 10) begin
        insn_bytes.push_back(xibe_pkg::OpEsc);
        insn_bytes.push_back(8'hC8 + q.d[2:0]);
      end else if (i >= 3 && i <= 6) begin
        insn_bytes.push_back(xibe_pkg::OpGrp2);
        insn_bytes.push_back(modrm(2'd3, one_ext[i], q.d[2:0]));
        insn_bytes.push_back(q.imm[7:0]);
      end else begin
        insn_bytes.push_back(8'hF7);
        insn_bytes.push_back(modrm(2'd3, one_ext[i], q.d[2:0]));
        if (i == 9) put32(q.imm[31:0]);
      end
    end else if (q.t <= 29) begin
      insn_bytes.push_back(rex(1'b0, q.d[3]));
      insn_bytes.push_back(xibe_pkg::OpGrp1);
      insn_bytes.push_back(modrm(2'd3, imm_ext[q.t - 24], q.d[2:0]));
      put32(q.imm[31:0]);
    end else if (q.t == 30) begin
      encode_mem(xibe_pkg::OpMovLd, q.d, q.s, q.disp);
    end else if (q.t == 31) begin
      encode_mem(xibe_pkg::OpMovStr, q.d, q.s, q.disp);
    end else if (q.t == 32) begin
      insn_bytes.push_back(xibe_pkg::OpJmp);
      put32(q.disp - 32'd4);
    end else if (q.t == 33) begin
      insn_bytes.push_back(xibe_pkg::OpEsc);
      insn_bytes.push_back(8'h80 | q.cc);
      put32(q.disp - 32'd4);
    end else if (q.t == 34) begin
      insn_bytes.push_back(xibe_pkg::OpCall);
      put32(q.disp - 32'd4);
    end else if (q.t == 35) begin
      insn_bytes.push_back(xibe_pkg::OpRet);
    end else if (q.t == 36) begin
      insn_bytes.push_back(xibe_pkg::OpCdq);
    end else if (q.t == 37) begin
      insn_bytes.push_back(8'h48);
      insn_bytes.push_back(xibe_pkg::OpCdq);
    end else if (q.t == 38) begin
      insn_bytes.push_back(8'h90);
    end else if (q.t == 39) begin
      insn_bytes.push_back(8'hCC);
    end
  endfunction

  function automatic void queue_bytes();
    byte_exp_t e;
    for (int k = 0; k < insn_bytes.size(); k++) begin
      e.b = insn_bytes[k];
      e.last = (k == insn_bytes.size() - 1);
      e.st = (byte_count < capacity) && (byte_count != 16'hFFFF);
      if (e.st) byte_count++;
      pending_bytes.push_back(e);
    end
  endfunction

  task automatic send_request(input insn_row_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_type_i <= q.t;
    dest_reg_i <= q.d;
    source_reg_i <= q.s;
    immediate_i <= q.imm;
    displacement_i <= q.disp;
    cond_code_i <= q.cc;
    do @(posedge clk_i); while (!req_ready_o);
    if (q.known) begin
      insn_bytes.delete();
      if (q.klen == 2) insn_bytes.push_back(q.kb[15:8]);
      if (q.klen >= 1) insn_bytes.push_back(q.kb[7:0]);
    end else begin
      build_encoding(q);
    end
    queue_bytes();
  endtask

  task automatic write_capacity(input logic [15:0] v);
    req_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = v;
    byte_count = '0;
  endtask

  function automatic insn_row_t mk(input logic [5:0] t, input logic [3:0] d,
                                   input logic [3:0] s, input logic [63:0] imm,
                                   input logic [31:0] disp, input logic [3:0] cc,
                                   input int klen = -1, input logic [15:0] kb = '0);
    insn_row_t q;
    q = '{t: t, d: d, s: s, imm: imm, disp: disp, cc: cc,
          known: (klen >= 0), klen: klen, kb: kb};
    return q;
  endfunction

  function automatic insn_row_t random_row();
    insn_row_t q;
    int r;
    q = mk(6'($urandom_range(0, 39)), 4'($urandom_range(0, 15)),
           4'($urandom_range(0, 15)), {$urandom, $urandom}, $urandom,
           4'($urandom_range(0, 15)));
    if ($urandom_range(0, 9) == 0) q.t = 6'($urandom_range(40, 63));
    r = $urandom_range(0, 5);
    if (r == 0) q.disp = '0;
    else if (r == 1) q.disp = $urandom_range(0, 255) - 128;
    else if (r == 2) q.disp = $urandom_range(0, 3) ? 32'hFFFFFF7F : 32'd128;
    r = $urandom_range(0, 7);
    if (r == 0) q.imm = '0;
    else if (r == 1) q.imm = '1;
    return q;
  endfunction

  // output side: check every accepted byte, then pick next ready
  always @(posedge clk_i) begin
    byte_exp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected byte %h", out_byte_o));
      end else begin
        e = pending_bytes.pop_front();
        if (out_byte_o !== e.b)
          report($sformatf("out_byte %h, want %h", out_byte_o, e.b));
        if (last_byte_o !== e.last)
          report($sformatf("last_byte %b, want %b", last_byte_o, e.last));
        if (stored_o !== e.st)
          report($sformatf("stored %b, want %b", stored_o, e.st));
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_stall = pick_gap();
      out_ready_i <= (out_stall == 0);
    end
  end

  initial begin
    logic [15:0] caps[5];
    capacity = '0;
    byte_count = '0;
    caps = '{16'd37, 16'hFFFF, 16'd0, 16'd1, 16'd0};
    caps[4] = 16'($urandom_range(20, 300));
    rows.push_back(mk(0, 15, 0, '1, 0, 0));
    rows.push_back(mk(0, 0, 0, '0, 0, 0));
    rows.push_back(mk(1, 8, 15, 0, 0, 0));
    rows.push_back(mk(7, 9, 2, 0, 0, 0));
    rows.push_back(mk(10, 3, 12, 0, 0, 15));
    rows.push_back(mk(11, 15, 8, 0, 0, 0));
    rows.push_back(mk(12, 1, 9, 0, 0, 0));
    rows.push_back(mk(13, 12, 0, 0, 0, 0));
    rows.push_back(mk(16, 7, 0, 64'hFF, 0, 0));
    rows.push_back(mk(22, 5, 0, 64'hFFFF_FFFF_8000_0000, 0, 0));
    rows.push_back(mk(23, 11, 0, 0, 0, 0));
    rows.push_back(mk(24, 0, 0, 64'h1234_5678_9ABC_DEF0, 0, 0));
    rows.push_back(mk(29, 14, 0, 64'h7FFF_FFFF, 0, 0));
    rows.push_back(mk(30, 2, 4, 0, 0, 0));
    rows.push_back(mk(30, 10, 13, 0, 0, 0));
    rows.push_back(mk(31, 6, 5, 0, 127, 0));
    rows.push_back(mk(31, 15, 12, 0, 32'hFFFFFF80, 0));
    rows.push_back(mk(30, 1, 3, 0, 32'hFFFFFF7F, 0));
    rows.push_back(mk(32, 0, 0, 0, 0, 0));
    rows.push_back(mk(33, 0, 0, 0, 32'h8000_0000, 0));
    rows.push_back(mk(34, 0, 0, 0, 32'h7FFF_FFFF, 0));
    rows.push_back(mk(35, 0, 0, 0, 0, 0, 1, 16'h00C3));
    rows.push_back(mk(36, 0, 0, 0, 0, 0, 1, 16'h0099));
    rows.push_back(mk(37, 0, 0, 0, 0, 0, 2, 16'h4899));
    rows.push_back(mk(38, 0, 0, 0, 0, 0, 1, 16'h0090));
    rows.push_back(mk(39, 0, 0, 0, 0, 0, 1, 16'h00CC));
    rows.push_back(mk(63, 15, 15, '1, '1, 15, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity is zero: nothing stored
    foreach (rows[i]) send_request(rows[i]);

    for (int p = 0; p < 5; p++) begin
      write_capacity(caps[p]);
      no_idle = (p == 1);
      repeat (37) send_request(random_row());
    end
    req_valid_i <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ x86_64_instruction_byte_encoder.f @@
design/xibe_pkg.sv
design/xibe_front.sv
design/xibe_back.sv
design/x86_64_instruction_byte_encoder.sv
sim/testbench.sv
